// File: rtl/qsk_pkg.sv
// Shared types, widths, constants and coefficient tables for the quintic kernel pipeline.
package qsk_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ETA_W   = 24;
  localparam int unsigned HDET_W  = 32;
  localparam int unsigned VN_W    = 32;
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned NLANE   = 3;

  // Term and power widths, Q.30 powers of a Q2.22 term of at most 3.0
  localparam int unsigned FRAC_W   = 22;
  localparam int unsigned SQ_SHIFT = 14;
  localparam int unsigned P2_W     = 34;
  localparam int unsigned P3_W     = 35;
  localparam int unsigned P4_W     = 37;
  localparam int unsigned P5_W     = 38;
  localparam int unsigned COEF_W   = 10;
  localparam int unsigned TERM_W   = 48;

  // Constant division by 3^n through a reciprocal and one correction step
  localparam int unsigned NUM_W     = 45;
  localparam int unsigned DIV_W     = 8;
  localparam int unsigned RECIP_W   = 41;
  localparam int unsigned DIV_SHIFT = 45;
  localparam int unsigned DIV_LO_W  = 22;
  localparam int unsigned PROD_W    = NUM_W + RECIP_W;
  localparam int unsigned QUO_W     = 41;

  // Final scaling by volume_norm * hdet
  localparam int unsigned GAIN_W    = VN_W + HDET_W;
  localparam int unsigned F_LO_W    = 20;
  localparam int unsigned G_LO_W    = 32;
  localparam int unsigned SL_W      = F_LO_W + GAIN_W;
  localparam int unsigned SH_W      = QUO_W - F_LO_W + GAIN_W;
  localparam int unsigned TOT_W     = SH_W + F_LO_W;
  localparam int unsigned RES_SHIFT = 46;
  localparam int unsigned RES_W     = TOT_W - RES_SHIFT;

  localparam logic [ETA_W-1:0] ONE_Q22   = ETA_W'(1) << FRAC_W;
  localparam logic [ETA_W-1:0] TWO_Q22   = ETA_W'(2) << FRAC_W;
  localparam logic [ETA_W-1:0] THREE_Q22 = ETA_W'(3) << FRAC_W;

  localparam logic [VN_W-1:0] VN_RESET = 32'd101921587;

  localparam logic [DIV_W-1:0] DIV_3P5 = 8'd243;
  localparam logic [DIV_W-1:0] DIV_3P4 = 8'd81;
  localparam logic [DIV_W-1:0] DIV_3P3 = 8'd27;
  localparam logic [DIV_W-1:0] HALF_3P5 = (DIV_3P5 - 8'd1) / 8'd2;
  localparam logic [DIV_W-1:0] HALF_3P4 = (DIV_3P4 - 8'd1) / 8'd2;
  localparam logic [DIV_W-1:0] HALF_3P3 = (DIV_3P3 - 8'd1) / 8'd2;
  localparam logic [RECIP_W-1:0] RECIP_3P5 = RECIP_W'((64'd1 << DIV_SHIFT) / 64'd243);
  localparam logic [RECIP_W-1:0] RECIP_3P4 = RECIP_W'((64'd1 << DIV_SHIFT) / 64'd81);
  localparam logic [RECIP_W-1:0] RECIP_3P3 = RECIP_W'((64'd1 << DIV_SHIFT) / 64'd27);

  localparam logic [TOT_W-1:0] RND_BIT = TOT_W'(1) << (RES_SHIFT - 1);
  localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

  localparam logic [1:0] LANE_A = 2'd0;
  localparam logic [1:0] LANE_B = 2'd1;
  localparam logic [1:0] LANE_C = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_VALUE  = 2'd0,
    FUNC_DERIV1 = 2'd1,
    FUNC_DERIV2 = 2'd2
  } func_e;

  typedef struct packed {
    logic              valid;
    logic              kill;
    logic              neg;
    logic [FUNC_W-1:0] func;
  } ctrl_t;

  function automatic logic signed [COEF_W-1:0] coef(input logic [FUNC_W-1:0] func,
                                                    input logic [1:0] lane);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case (func)
      FUNC_VALUE: begin
        case (lane)
          LANE_A:  c = 10'sd1;
          LANE_B:  c = -10'sd6;
          LANE_C:  c = 10'sd15;
          default: c = '0;
        endcase
      end
      FUNC_DERIV1: begin
        case (lane)
          LANE_A:  c = -10'sd5;
          LANE_B:  c = 10'sd30;
          LANE_C:  c = -10'sd75;
          default: c = '0;
        endcase
      end
      FUNC_DERIV2: begin
        case (lane)
          LANE_A:  c = 10'sd20;
          LANE_B:  c = -10'sd120;
          LANE_C:  c = 10'sd300;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [DIV_W-1:0] divisor(input logic [FUNC_W-1:0] func);
    logic [DIV_W-1:0] d;
    case (func)
      FUNC_VALUE:  d = DIV_3P5;
      FUNC_DERIV1: d = DIV_3P4;
      default:     d = DIV_3P3;
    endcase
    return d;
  endfunction

  function automatic logic [DIV_W-1:0] half_div(input logic [FUNC_W-1:0] func);
    logic [DIV_W-1:0] h;
    case (func)
      FUNC_VALUE:  h = HALF_3P5;
      FUNC_DERIV1: h = HALF_3P4;
      default:     h = HALF_3P3;
    endcase
    return h;
  endfunction

  function automatic logic [RECIP_W-1:0] recip(input logic [FUNC_W-1:0] func);
    logic [RECIP_W-1:0] m;
    case (func)
      FUNC_VALUE:  m = RECIP_3P5;
      FUNC_DERIV1: m = RECIP_3P4;
      default:     m = RECIP_3P3;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/qsk_poly.sv
// Terms, power chain, weighted sum and rounded magnitude: pipeline stages one to eight.
module qsk_poly (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  qsk_pkg::ctrl_t               ctrl_i,
  input  logic [qsk_pkg::ETA_W-1:0]    eta_i,
  input  logic [qsk_pkg::HDET_W-1:0]   hdet_i,
  output qsk_pkg::ctrl_t               ctrl_o,
  output logic [qsk_pkg::NUM_W-1:0]    num_o,
  output logic [qsk_pkg::HDET_W-1:0]   hdet_o
);

  localparam int unsigned NSTG = 8;
  localparam int unsigned XW   = qsk_pkg::ETA_W;
  localparam int unsigned FW   = qsk_pkg::FRAC_W;

  qsk_pkg::ctrl_t ctrl_q [NSTG];
  qsk_pkg::ctrl_t ctrl_last_d;
  logic [qsk_pkg::HDET_W-1:0] hdet_q [NSTG];

  logic [XW+1:0] eta3;
  logic [XW-1:0] x1_d [qsk_pkg::NLANE];
  logic [XW-1:0] x1_q [qsk_pkg::NLANE];
  logic [XW-1:0] x2_q [qsk_pkg::NLANE];
  logic [XW-1:0] x3_q [qsk_pkg::NLANE];
  logic [XW-1:0] x4_q [qsk_pkg::NLANE];

  logic [2*XW-1:0]                 sq   [qsk_pkg::NLANE];
  logic [qsk_pkg::P2_W+XW-1:0]     pr3  [qsk_pkg::NLANE];
  logic [qsk_pkg::P3_W+XW-1:0]     pr4  [qsk_pkg::NLANE];
  logic [qsk_pkg::P4_W+XW-1:0]     pr5  [qsk_pkg::NLANE];
  logic [qsk_pkg::P2_W-1:0]        p2_q [qsk_pkg::NLANE];
  logic [qsk_pkg::P3_W-1:0]        p3_q [qsk_pkg::NLANE];
  logic [qsk_pkg::P4_W-1:0]        p4_d [qsk_pkg::NLANE];
  logic [qsk_pkg::P4_W-1:0]        p4_q [qsk_pkg::NLANE];
  logic [qsk_pkg::P5_W-1:0]        p5_d [qsk_pkg::NLANE];
  logic [qsk_pkg::P5_W-1:0]        p5_q [qsk_pkg::NLANE];
  logic signed [qsk_pkg::TERM_W-1:0] t_d [qsk_pkg::NLANE];
  logic signed [qsk_pkg::TERM_W-1:0] t_q [qsk_pkg::NLANE];
  logic signed [qsk_pkg::TERM_W-1:0] sum_d, sum_q;
  logic [qsk_pkg::TERM_W-1:0]      abs_s;
  logic [qsk_pkg::NUM_W-1:0]       num_d, num_q;

  // Terms are taken times three so that the interval tests are exact
  assign eta3 = {1'b0, eta_i, 1'b0} + {2'b00, eta_i};

  always_comb begin
    x1_d[qsk_pkg::LANE_A] = qsk_pkg::THREE_Q22 - eta3[XW-1:0];
    x1_d[qsk_pkg::LANE_B] = (eta3 < {2'b00, qsk_pkg::TWO_Q22}) ?
                            qsk_pkg::TWO_Q22 - eta3[XW-1:0] : '0;
    x1_d[qsk_pkg::LANE_C] = (eta3 < {2'b00, qsk_pkg::ONE_Q22}) ?
                            qsk_pkg::ONE_Q22 - eta3[XW-1:0] : '0;
    if (ctrl_i.kill) begin
      for (int t = 0; t < qsk_pkg::NLANE; t++) begin
        x1_d[t] = '0;
      end
    end
  end

  always_comb begin
    for (int t = 0; t < qsk_pkg::NLANE; t++) begin
      sq[t]  = x1_q[t] * x1_q[t];
      pr3[t] = p2_q[t] * x2_q[t];
      pr4[t] = p3_q[t] * x3_q[t];
      pr5[t] = p4_q[t] * x4_q[t];
      // Stop the chain at the power the selected quantity needs
      if (ctrl_q[2].func != qsk_pkg::FUNC_DERIV2) begin
        p4_d[t] = pr4[t][FW+qsk_pkg::P4_W-1:FW];
      end else begin
        p4_d[t] = qsk_pkg::P4_W'(p3_q[t]);
      end
      if (ctrl_q[3].func == qsk_pkg::FUNC_VALUE) begin
        p5_d[t] = pr5[t][FW+qsk_pkg::P5_W-1:FW];
      end else begin
        p5_d[t] = qsk_pkg::P5_W'(p4_q[t]);
      end
      t_d[t] = $signed({1'b0, p5_q[t]}) * qsk_pkg::coef(ctrl_q[4].func, 2'(t));
    end
  end

  assign sum_d = t_q[qsk_pkg::LANE_A] + t_q[qsk_pkg::LANE_B] + t_q[qsk_pkg::LANE_C];
  assign abs_s = sum_q[qsk_pkg::TERM_W-1] ? qsk_pkg::TERM_W'(-sum_q) : sum_q;
  assign num_d = abs_s[qsk_pkg::NUM_W-1:0] +
                 qsk_pkg::NUM_W'(qsk_pkg::half_div(ctrl_q[6].func));

  always_comb begin
    ctrl_last_d     = ctrl_q[NSTG-2];
    ctrl_last_d.neg = sum_q[qsk_pkg::TERM_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) begin
        ctrl_q[k] <= '0;
      end
    end else if (en_i) begin
      ctrl_q[0] <= ctrl_i;
      for (int k = 1; k < NSTG - 1; k++) begin
        ctrl_q[k] <= ctrl_q[k-1];
      end
      ctrl_q[NSTG-1] <= ctrl_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hdet_q[0] <= hdet_i;
      for (int k = 1; k < NSTG; k++) begin
        hdet_q[k] <= hdet_q[k-1];
      end
      for (int t = 0; t < qsk_pkg::NLANE; t++) begin
        x1_q[t] <= x1_d[t];
        x2_q[t] <= x1_q[t];
        p2_q[t] <= sq[t][2*XW-1:qsk_pkg::SQ_SHIFT];
        x3_q[t] <= x2_q[t];
        p3_q[t] <= pr3[t][FW+qsk_pkg::P3_W-1:FW];
        x4_q[t] <= x3_q[t];
        p4_q[t] <= p4_d[t];
        p5_q[t] <= p5_d[t];
        t_q[t]  <= t_d[t];
      end
      sum_q <= sum_d;
      num_q <= num_d;
    end
  end

  assign ctrl_o = ctrl_q[NSTG-1];
  assign num_o  = num_q;
  assign hdet_o = hdet_q[NSTG-1];

endmodule

// File: rtl/qsk_cdiv.sv
// Rounded division by 3^n through a split reciprocal product and one correction; gain product.
module qsk_cdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  qsk_pkg::ctrl_t                ctrl_i,
  input  logic [qsk_pkg::NUM_W-1:0]     num_i,
  input  logic [qsk_pkg::HDET_W-1:0]    hdet_i,
  input  logic [qsk_pkg::VN_W-1:0]      vn_i,
  output qsk_pkg::ctrl_t                ctrl_o,
  output logic [qsk_pkg::QUO_W-1:0]     quo_o,
  output logic [qsk_pkg::GAIN_W-1:0]    gain_o
);

  localparam int unsigned NSTG  = 4;
  localparam int unsigned NW    = qsk_pkg::NUM_W;
  localparam int unsigned LW    = qsk_pkg::DIV_LO_W;
  localparam int unsigned RW    = qsk_pkg::RECIP_W;
  localparam int unsigned QW    = qsk_pkg::QUO_W;

  qsk_pkg::ctrl_t ctrl_q [NSTG];

  logic [NW-LW+RW-1:0]             ph_d, ph_q;
  logic [LW+RW-1:0]                pl_d, pl_q;
  logic [NW-1:0]                   num9_q, num10_q;
  logic [qsk_pkg::HDET_W-1:0]      hdet9_q, hdet10_q;
  logic [qsk_pkg::PROD_W-1:0]      psum;
  logic [QW-1:0]                   q0_q, q1_q;
  logic [QW+qsk_pkg::DIV_W-1:0]    qd;
  logic [NW-1:0]                   rem_d, rem_q;
  logic [qsk_pkg::GAIN_W-1:0]      gain_d, gain11_q, gain_q;
  logic [QW-1:0]                   quo_d, quo_q;
  logic [qsk_pkg::DIV_W-1:0]       div11;

  assign ph_d  = num_i[NW-1:LW] * qsk_pkg::recip(ctrl_i.func);
  assign pl_d  = num_i[LW-1:0] * qsk_pkg::recip(ctrl_i.func);
  assign psum  = {ph_q, {LW{1'b0}}} + qsk_pkg::PROD_W'(pl_q);
  assign qd    = q0_q * qsk_pkg::divisor(ctrl_q[1].func);
  assign rem_d = num10_q - qd[NW-1:0];
  assign gain_d = vn_i * hdet10_q;
  // The estimate is low by at most one: bump it when the remainder reaches the divisor
  assign div11 = qsk_pkg::divisor(ctrl_q[2].func);
  assign quo_d = q1_q + QW'(rem_q >= NW'(div11));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) begin
        ctrl_q[k] <= '0;
      end
    end else if (en_i) begin
      ctrl_q[0] <= ctrl_i;
      for (int k = 1; k < NSTG; k++) begin
        ctrl_q[k] <= ctrl_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q     <= ph_d;
      pl_q     <= pl_d;
      num9_q   <= num_i;
      hdet9_q  <= hdet_i;
      q0_q     <= psum[qsk_pkg::PROD_W-1:qsk_pkg::DIV_SHIFT];
      num10_q  <= num9_q;
      hdet10_q <= hdet9_q;
      rem_q    <= rem_d;
      q1_q     <= q0_q;
      gain11_q <= gain_d;
      quo_q    <= quo_d;
      gain_q   <= gain11_q;
    end
  end

  // num10_q holds the numerator that q0_q was formed from
  assign ctrl_o = ctrl_q[NSTG-1];
  assign quo_o  = quo_q;
  assign gain_o = gain_q;

endmodule

// File: rtl/qsk_scale.sv
// Split product of quotient and gain, rounding, saturation and the output register.
module qsk_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  qsk_pkg::ctrl_t                ctrl_i,
  input  logic [qsk_pkg::QUO_W-1:0]     quo_i,
  input  logic [qsk_pkg::GAIN_W-1:0]    gain_i,
  output logic                          valid_o,
  output logic [qsk_pkg::OUT_W-1:0]     kernel_o,
  output logic                          sat_o
);

  localparam int unsigned NSTG = 4;
  localparam int unsigned FLW  = qsk_pkg::F_LO_W;
  localparam int unsigned FHW  = qsk_pkg::QUO_W - qsk_pkg::F_LO_W;
  localparam int unsigned GLW  = qsk_pkg::G_LO_W;
  localparam int unsigned GHW  = qsk_pkg::GAIN_W - qsk_pkg::G_LO_W;

  qsk_pkg::ctrl_t ctrl_q [NSTG];

  logic [FLW+GLW-1:0] pll_q;
  logic [FLW+GHW-1:0] plh_q;
  logic [FHW+GLW-1:0] phl_q;
  logic [FHW+GHW-1:0] phh_q;
  logic [qsk_pkg::SL_W-1:0]  sl_d, sl_q;
  logic [qsk_pkg::SH_W-1:0]  sh_d, sh_q;
  logic [qsk_pkg::TOT_W-1:0] tot;
  logic [qsk_pkg::RES_W-1:0] res_q;
  logic [qsk_pkg::OUT_W-1:0] kernel_d, kernel_q;
  logic                      sat_d, sat_q;

  assign sl_d = {plh_q, {GLW{1'b0}}} + qsk_pkg::SL_W'(pll_q);
  assign sh_d = {phh_q, {GLW{1'b0}}} + qsk_pkg::SH_W'(phl_q);
  assign tot  = qsk_pkg::TOT_W'(sl_q) + {sh_q, {FLW{1'b0}}} + qsk_pkg::RND_BIT;

  always_comb begin
    kernel_d = '0;
    sat_d    = 1'b0;
    if (!ctrl_q[2].kill) begin
      if (ctrl_q[2].neg) begin
        if (res_q > qsk_pkg::RES_W'(qsk_pkg::NEG_LIMIT)) begin
          kernel_d = qsk_pkg::NEG_LIMIT;
          sat_d    = 1'b1;
        end else begin
          kernel_d = qsk_pkg::OUT_W'(-res_q[qsk_pkg::OUT_W-1:0]);
        end
      end else begin
        if (res_q > qsk_pkg::RES_W'(qsk_pkg::POS_LIMIT)) begin
          kernel_d = qsk_pkg::POS_LIMIT;
          sat_d    = 1'b1;
        end else begin
          kernel_d = res_q[qsk_pkg::OUT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) begin
        ctrl_q[k] <= '0;
      end
    end else if (en_i) begin
      ctrl_q[0] <= ctrl_i;
      for (int k = 1; k < NSTG; k++) begin
        ctrl_q[k] <= ctrl_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pll_q    <= quo_i[FLW-1:0] * gain_i[GLW-1:0];
      plh_q    <= quo_i[FLW-1:0] * gain_i[qsk_pkg::GAIN_W-1:GLW];
      phl_q    <= quo_i[qsk_pkg::QUO_W-1:FLW] * gain_i[GLW-1:0];
      phh_q    <= quo_i[qsk_pkg::QUO_W-1:FLW] * gain_i[qsk_pkg::GAIN_W-1:GLW];
      sl_q     <= sl_d;
      sh_q     <= sh_d;
      res_q    <= tot[qsk_pkg::TOT_W-1:qsk_pkg::RES_SHIFT];
      kernel_q <= kernel_d;
      sat_q    <= sat_d;
    end
  end

  assign valid_o  = ctrl_q[NSTG-1].valid;
  assign kernel_o = kernel_q;
  assign sat_o    = sat_q;

endmodule

// File: rtl/quintic_spline_kernel_eval_top.sv
// Quintic spline kernel evaluator: normalization register, stream ports and pipeline chain.
// An accepted input word runs through qsk_poly, qsk_cdiv and qsk_scale to the master side.
// Throughput: one word per cycle unless stalled; every stage is a register and the chain
// has no loops. Backpressure stalls the whole chain at once; the slave side is ready while
// the output register is empty or being drained.
// Reset: asynchronous, active low; clears all valid bits and loads volume_norm with 3^5/40.
module quintic_spline_kernel_eval_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [31:0] cfg_wr_data_i,   // volume_norm, unsigned Q8.24
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,    // [23:0] eta Q2.22, [55:24] hdet Q16.16
  input  logic [1:0]  s_axis_tuser,    // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // [47:0] kernel_out, signed Q24.24
  output logic [0:0]  m_axis_tuser     // [0] saturated
);

  logic [qsk_pkg::VN_W-1:0] vn_q;
  logic                     adv;
  logic                     in_kill;
  qsk_pkg::ctrl_t           in_ctrl, poly_ctrl, cdiv_ctrl;
  logic [qsk_pkg::ETA_W-1:0]  eta;
  logic [qsk_pkg::HDET_W-1:0] hdet, poly_hdet;
  logic [qsk_pkg::NUM_W-1:0]  poly_num;
  logic [qsk_pkg::QUO_W-1:0]  cdiv_quo;
  logic [qsk_pkg::GAIN_W-1:0] cdiv_gain;
  logic                       sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= qsk_pkg::VN_RESET;
    end else if (cfg_wr_en_i) begin
      vn_q <= cfg_wr_data_i;
    end
  end

  // Advance the chain whenever the output register is free or being taken
  assign adv           = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = adv;

  assign eta  = s_axis_tdata[qsk_pkg::ETA_W-1:0];
  assign hdet = s_axis_tdata[qsk_pkg::ETA_W+qsk_pkg::HDET_W-1:qsk_pkg::ETA_W];

  // Drop to zero outside the support and for the unused selector code
  assign in_kill = !(s_axis_tuser inside {qsk_pkg::FUNC_VALUE, qsk_pkg::FUNC_DERIV1,
                                          qsk_pkg::FUNC_DERIV2})
                   || (eta >= qsk_pkg::ONE_Q22);

  always_comb begin
    in_ctrl       = '0;
    in_ctrl.valid = s_axis_tvalid;
    in_ctrl.kill  = in_kill;
    in_ctrl.func  = s_axis_tuser;
  end

  qsk_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctrl_i (in_ctrl),
    .eta_i  (eta),
    .hdet_i (hdet),
    .ctrl_o (poly_ctrl),
    .num_o  (poly_num),
    .hdet_o (poly_hdet)
  );

  qsk_cdiv u_cdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctrl_i (poly_ctrl),
    .num_i  (poly_num),
    .hdet_i (poly_hdet),
    .vn_i   (vn_q),
    .ctrl_o (cdiv_ctrl),
    .quo_o  (cdiv_quo),
    .gain_o (cdiv_gain)
  );

  qsk_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .ctrl_i   (cdiv_ctrl),
    .quo_i    (cdiv_quo),
    .gain_i   (cdiv_gain),
    .valid_o  (m_axis_tvalid),
    .kernel_o (m_axis_tdata),
    .sat_o    (sat)
  );

  assign m_axis_tuser = sat;

`ifndef SYNTHESIS
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata == qsk_pkg::POS_LIMIT) || (m_axis_tdata == qsk_pkg::NEG_LIMIT))
    else $error("saturation flag set on an unclipped word");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while the output word is stalled");

  a_zero_not_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata == '0) |-> !m_axis_tuser[0])
    else $error("zero word flagged as saturated");
`endif

endmodule
